@@ rtl/lil_pkg.sv @@
// lil_pkg: shared types and constants of the breakpoint interpolation block.
// No dependencies; the channel interfaces and the top level use it.
`default_nettype none

package lil_pkg;

   // Q16.16 data word
   localparam int DATA_W = 32;
   typedef logic signed [DATA_W-1:0] data_type;

   // Input item fields
   localparam int INDEX_W = 6;
   typedef logic [INDEX_W-1:0] index_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // points_used register
   localparam int CFG_W = 7;
   typedef logic [CFG_W-1:0] cfg_type;
   localparam cfg_type POINTS_USED_RESET = 7'd2;
   localparam int MIN_POINTS = 2;

   // Long division: one quotient bit per step
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

endpackage

`default_nettype wire

@@ rtl/lil_if.sv @@
// lil_if: valid/ready channel interfaces for the request, response and CSR sides.
// Depends on lil_pkg for the payload types.
`default_nettype none

interface lil_req_if;
   logic                valid;
   logic                ready;
   logic                mode;
   lil_pkg::index_type  point_index;
   lil_pkg::data_type   point_x;
   lil_pkg::data_type   point_y;
   lil_pkg::data_type   query_x;

   modport source (output valid, mode, point_index, point_x, point_y, query_x,
                   input ready);
   modport sink   (input valid, mode, point_index, point_x, point_y, query_x,
                   output ready);
endinterface

interface lil_rsp_if;
   logic                valid;
   logic                ready;
   lil_pkg::data_type   value_y;
   logic                out_of_range;

   modport source (output valid, value_y, out_of_range, input ready);
   modport sink   (input valid, value_y, out_of_range, output ready);
endinterface

interface lil_csr_if;
   logic                valid;
   logic                ready;
   lil_pkg::cfg_type    points_used;

   modport source (output valid, points_used, input ready);
   modport sink   (input valid, points_used, output ready);
endinterface

`default_nettype wire

@@ rtl/linear_interp_lookup_core.sv @@
// linear_interp_lookup_core: piecewise linear interpolation over a breakpoint table.
// Depends on lil_pkg (types, constants) and lil_if (channel interfaces).
//
//   channel   | dir | payload                                         | transaction
//   ----------+-----+-------------------------------------------------+-------------------------
//   req_chan  | in  | mode, point_index, point_x, point_y, query_x    | load or query one item
//   rsp_chan  | out | value_y, out_of_range                           | one per query, none per load
//   csr_chan  | in  | points_used                                     | write points_used
//
// A load is written into the table as it is accepted. A query that falls outside the table
// goes from S_CHECK to S_DONE; a query equal to the first x stops on entry 0 in S_SCAN;
// any other one inside scans on until it finds the upper breakpoint of its segment:
// the scan reads one table entry per cycle through the single read port, and the
// lower point arrives in S_LO, the product is formed in S_MUL and divided in S_DIV.
// Reset clears the sequencer, the response valid and points_used (back to 2);
// the table itself holds garbage until loaded. A stalled response holds in its
// output register while loads keep going; a finished query waits for it.
`default_nettype none

module linear_interp_lookup_core #(
   parameter int MAX_POINTS = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   lil_req_if.sink       req_chan,
   lil_rsp_if.source     rsp_chan,
   lil_csr_if.sink       csr_chan
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DW = lil_pkg::DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAST,
      S_CHECK,
      S_SCAN,
      S_LO,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type                     state_ff, state_in;
   lil_pkg::cfg_type              points_used_ff, points_used_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lil_pkg::data_type             rsp_value_ff, rsp_value_in;
   logic                          rsp_oor_ff, rsp_oor_in;

   lil_pkg::data_type             q_ff, q_in;
   logic [AW-1:0]                 last_ff, last_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   lil_pkg::data_type             first_x_ff, first_x_in;
   lil_pkg::data_type             x1_ff, x1_in;
   lil_pkg::data_type             y1_ff, y1_in;
   lil_pkg::data_type             y0_ff, y0_in;
   logic [DW-1:0]                 dx_ff, dx_in;
   logic [DW-1:0]                 dq_ff, dq_in;
   logic [DW-1:0]                 mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic                          oor_ff, oor_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   logic [DW-1:0]                 lo_ff, lo_in;
   logic [lil_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Breakpoint table and its registered read port
   lil_pkg::data_type             mem_x [MAX_POINTS];
   lil_pkg::data_type             mem_y [MAX_POINTS];
   lil_pkg::data_type             rd_x_ff;
   lil_pkg::data_type             rd_y_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          mem_we;
   logic [AW-1:0]                 wr_addr;

   // ---------------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------------
   logic                          req_fire;
   logic                          rsp_free;
   logic [31:0]                   pu_wide;
   logic [AW-1:0]                 last_calc;
   logic                          found;
   logic [DW:0]                   dy_pos;
   logic [DW-1:0]                 dy_neg;
   logic [2*DW-1:0]               prod;
   logic [DW:0]                   div_trial;
   logic [DW:0]                   div_diff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.value_y      = rsp_value_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

   // Clamp points_used into [2, MAX_POINTS] and take the index of the last entry
   assign pu_wide = 32'(points_used_ff);
   always_comb begin
      if (pu_wide < 32'(lil_pkg::MIN_POINTS)) begin
         last_calc = AW'(lil_pkg::MIN_POINTS - 1);
      end else if (pu_wide > 32'(MAX_POINTS)) begin
         last_calc = AW'(MAX_POINTS - 1);
      end else begin
         last_calc = AW'(pu_wide - 32'd1);
      end
   end

   // Drop loads beyond the table
   assign wr_addr = AW'(req_chan.point_index);
   assign mem_we  = req_fire && (req_chan.mode == lil_pkg::MODE_LOAD) &&
                    (32'(req_chan.point_index) < 32'(MAX_POINTS));

   // Scan stops at the first entry at or above the query, or at the last one
   assign found = (idx_ff == last_ff) || (rd_x_ff >= q_ff);

   // Slope magnitude: both differences in parallel, pick by sign
   assign dy_pos = {y1_ff[DW-1], y1_ff} - {rd_y_ff[DW-1], rd_y_ff};
   assign dy_neg = rd_y_ff - y1_ff;

   assign prod = (2*DW)'(mag_ff) * (2*DW)'(dq_ff);

   // Restoring-division step
   assign div_trial = {rem_ff, lo_ff[DW-1]};
   assign div_diff  = div_trial - {1'b0, dx_ff};

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      points_used_in = points_used_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_oor_in     = rsp_oor_ff;
      q_in           = q_ff;
      last_in        = last_ff;
      idx_in         = idx_ff;
      first_x_in     = first_x_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      y0_in          = y0_ff;
      dx_in          = dx_ff;
      dq_in          = dq_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      oor_in         = oor_ff;
      rem_in         = rem_ff;
      lo_in          = lo_ff;
      cnt_in         = cnt_ff;
      rd_addr        = '0;

      if (csr_chan.valid && csr_chan.ready) begin
         points_used_in = csr_chan.points_used;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Entry 0 is read every idle cycle; its data lands in S_LAST
            if (req_fire && (req_chan.mode == lil_pkg::MODE_QUERY)) begin
               q_in     = req_chan.query_x;
               last_in  = last_calc;
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            first_x_in = rd_x_ff;
            rd_addr    = last_ff;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if ((q_ff < first_x_ff) || (q_ff > rd_x_ff)) begin
               oor_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (found) begin
               x1_in = rd_x_ff;
               y1_in = rd_y_ff;
               if (idx_ff == '0) begin
                  // Query sits on the first breakpoint: return its y as is
                  y0_in    = rd_y_ff;
                  lo_in    = '0;
                  neg_in   = 1'b0;
                  oor_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  rd_addr  = idx_ff - AW'(1);
                  state_in = S_LO;
               end
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         S_LO: begin
            y0_in    = rd_y_ff;
            dx_in    = x1_ff - rd_x_ff;
            dq_in    = q_ff - rd_x_ff;
            neg_in   = dy_pos[DW];
            mag_in   = dy_pos[DW] ? dy_neg : dy_pos[DW-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            rem_in   = prod[2*DW-1:DW];
            lo_in    = prod[DW-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_diff[DW]) begin
               rem_in = div_diff[DW-1:0];
               lo_in  = {lo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = div_trial[DW-1:0];
               lo_in  = {lo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lil_pkg::DIV_LAST) begin
               oor_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_oor_in   = oor_ff;
               if (oor_ff) begin
                  rsp_value_in = '0;
               end else if (neg_ff) begin
                  rsp_value_in = y0_ff - lo_ff;
               end else begin
                  rsp_value_in = y0_ff + lo_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         points_used_ff <= lil_pkg::POINTS_USED_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         points_used_ff <= points_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
      q_ff         <= q_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      first_x_ff   <= first_x_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      y0_ff        <= y0_in;
      dx_ff        <= dx_in;
      dq_ff        <= dq_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      oor_ff       <= oor_in;
      rem_ff       <= rem_in;
      lo_ff        <= lo_in;
      cnt_ff       <= cnt_in;
   end

   // ---------------------------------------------------------------------------
   // Breakpoint table: one write, one registered read per cycle
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[wr_addr] <= req_chan.point_x;
         mem_y[wr_addr] <= req_chan.point_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < dx_ff))
      else $error("division remainder not below divisor");

   a_lower_knot_below_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LO) |-> (rd_x_ff < q_ff))
      else $error("lower breakpoint not below query");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_value_ff == '0))
      else $error("out-of-range response carries nonzero value");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> !(($past(state_ff) == S_DIV) && req_fire))
      else $error("request accepted while dividing");

endmodule

`default_nettype wire

@@ verif/linear_interp_lookup_core_tb.sv @@
// linear_interp_lookup_core_tb: self-checking bench for the breakpoint interpolation core.
// Depends on lil_pkg, the lil_if channel interfaces and linear_interp_lookup_core; a
// scoreboard class keeps its own breakpoint table and predicts every lookup.

module linear_interp_lookup_core_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_GOAL = 400;
   // margin beyond the longest query, whose scan reaches upper index 63
   localparam int SETTLE_CYCLES = 120;
   localparam int IDLE_CYCLES = 8;
   localparam longint Q_MIN = -64'sd2147483648;
   localparam longint Q_MAX = 64'sd2147483647;

   typedef struct {
      logic               mode;
      lil_pkg::index_type point_index;
      lil_pkg::data_type  point_x;
      lil_pkg::data_type  point_y;
      lil_pkg::data_type  query_x;
   } lookup_item_type;

   typedef struct {
      lil_pkg::data_type value_y;
      logic              out_of_range;
   } lookup_result_type;

   // Scoreboard: mirrors the breakpoint table and points_used, queues the
   // expected answer of each accepted query and checks results in order.
   class interp_scoreboard;
      lil_pkg::data_type  knot_x[TABLE_DEPTH];
      lil_pkg::data_type  knot_y[TABLE_DEPTH];
      lil_pkg::cfg_type   points_used;
      lookup_result_type  expected_q[$];
      int unsigned        error_count;
      int unsigned        lookup_count;

      function new();
         points_used = lil_pkg::POINTS_USED_RESET;
         error_count = 0;
         lookup_count = 0;
      endfunction

      function int unsigned active_points();
         if (points_used < lil_pkg::MIN_POINTS) return lil_pkg::MIN_POINTS;
         if (points_used > TABLE_DEPTH) return TABLE_DEPTH;
         return points_used;
      endfunction

      function void set_points_used(lil_pkg::cfg_type value);
         points_used = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function lookup_result_type interpolate(lil_pkg::data_type q);
         int unsigned       n;
         int unsigned       k;
         longint            x0, x1, y0, y1, dy, res;
         bit [63:0]         dx, dq, mag, quo;
         lookup_result_type r;
         n = active_points();
         r.value_y = '0;
         r.out_of_range = 1'b1;
         if (q < knot_x[0] || q > knot_x[n-1]) return r;
         r.out_of_range = 1'b0;
         k = 0;
         while (k < n - 1 && knot_x[k] < q) k++;
         if (k == 0) begin
            r.value_y = knot_y[0];
            return r;
         end
         x0 = knot_x[k-1];
         x1 = knot_x[k];
         y0 = knot_y[k-1];
         y1 = knot_y[k];
         dx = x1 - x0;
         dq = longint'(q) - x0;
         dy = y1 - y0;
         mag = (dy < 0) ? -dy : dy;
         quo = (mag * dq) / dx;
         res = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
         r.value_y = res[31:0];
         return r;
      endfunction

      function void note_transaction(lookup_item_type item);
         if (item.mode == lil_pkg::MODE_LOAD) begin
            knot_x[item.point_index] = item.point_x;
            knot_y[item.point_index] = item.point_y;
         end else begin
            expected_q.push_back(interpolate(item.query_x));
         end
      endfunction

      task report(string msg);
         $display("MISMATCH lookup %0d: %s", lookup_count, msg);
         error_count++;
      endtask

      task check_result(lil_pkg::data_type value_y, logic out_of_range);
         lookup_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending: value_y=%h out_of_range=%b",
                             value_y, out_of_range));
            return;
         end
         want = expected_q.pop_front();
         if (value_y !== want.value_y)
            report($sformatf("value_y %h, expected %h", value_y, want.value_y));
         if (out_of_range !== want.out_of_range)
            report($sformatf("out_of_range %b, expected %b", out_of_range, want.out_of_range));
         lookup_count++;
      endtask
   endclass

   logic clock;
   logic reset;

   lil_req_if req_chan();
   lil_rsp_if rsp_chan();
   lil_csr_if csr_chan();

   linear_interp_lookup_core #(.MAX_POINTS(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   interp_scoreboard lookup_board = new();

   int unsigned item_count = 0;
   int unsigned burst_left = 1;
   bit          steady_feed = 1'b0;
   int unsigned open_left = 0;
   int unsigned stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit: end the run with errors if it never finishes.
   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response back-pressure: alternate open windows and stalls of random length,
   // with long open stretches now and then so results also stream freely.
   always @(posedge clock) begin
      if (open_left != 0) begin
         open_left <= open_left - 1;
         rsp_chan.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         open_left <= ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
         stall_left <= $urandom_range(9, 0);
         rsp_chan.ready <= 1'b1;
      end
   end

   // Check every response transaction against the oldest pending prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         lookup_board.check_result(rsp_chan.value_y, rsp_chan.out_of_range);
   end

   // Drive one request transaction, hold it until accepted, then note it.
   // Outside steady stretches, close each burst with a random gap.
   task automatic send_item(input lookup_item_type item);
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= item.mode;
      req_chan.point_index <= item.point_index;
      req_chan.point_x     <= item.point_x;
      req_chan.point_y     <= item.point_y;
      req_chan.query_x     <= item.query_x;
      do @(posedge clock); while (!req_chan.ready);
      lookup_board.note_transaction(item);
      item_count++;
      if (!steady_feed) begin
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(12, 1);
            req_chan.valid <= 1'b0;
            repeat (($urandom_range(3) == 0) ? $urandom_range(60, 7) : $urandom_range(6, 1))
               @(posedge clock);
         end
      end
   endtask

   // Load: unused query_x gets noise.
   task automatic load_point(input int unsigned idx, input lil_pkg::data_type x,
                             input lil_pkg::data_type y);
      lookup_item_type item;
      item.mode = lil_pkg::MODE_LOAD;
      item.point_index = lil_pkg::index_type'(idx);
      item.point_x = x;
      item.point_y = y;
      item.query_x = $urandom;
      send_item(item);
   endtask

   // Query: unused point fields get noise.
   task automatic query_at(input lil_pkg::data_type q);
      lookup_item_type item;
      item.mode = lil_pkg::MODE_QUERY;
      item.point_index = lil_pkg::index_type'($urandom);
      item.point_x = $urandom;
      item.point_y = $urandom;
      item.query_x = q;
      send_item(item);
   endtask

   // Drop valid and hold off until every predicted result has come back,
   // then give loads still in flight time to land.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (lookup_board.pending() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Write points_used only with the core idle.
   task automatic write_points_used(input lil_pkg::cfg_type value);
      wait_drained();
      csr_chan.valid <= 1'b1;
      csr_chan.points_used <= value;
      do @(posedge clock); while (!csr_chan.ready);
      lookup_board.set_points_used(value);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic lil_pkg::data_type knot(input int unsigned idx);
      return lookup_board.knot_x[idx];
   endfunction

   function automatic lil_pkg::cfg_type pick_points_used();
      case ($urandom_range(9))
         0:       return lil_pkg::cfg_type'($urandom_range(1));       // below minimum, acts as two
         1:       return lil_pkg::cfg_type'($urandom_range(127, 65)); // past the table, acts as full
         2, 3:    return lil_pkg::cfg_type'(TABLE_DEPTH);
         4, 5:    return lil_pkg::cfg_type'($urandom_range(TABLE_DEPTH, 2));
         default: return lil_pkg::cfg_type'($urandom_range(10, 2));
      endcase
   endfunction

   // Mostly points inside a segment, then exact breakpoints, near misses
   // just outside the table, and raw noise.
   function automatic lil_pkg::data_type pick_query();
      int unsigned n, k, pick;
      longint      lo, hi, q;
      n = lookup_board.active_points();
      pick = $urandom_range(99);
      k = $urandom_range(n - 1, 1);
      lo = lookup_board.knot_x[k-1];
      hi = lookup_board.knot_x[k];
      if (pick < 55 && hi > lo)
         q = lo + longint'($urandom_range(32'(hi - lo)));
      else if (pick < 70)
         q = lookup_board.knot_x[$urandom_range(n - 1)];
      else if (pick < 85)
         q = $urandom_range(1)
             ? longint'(lookup_board.knot_x[0]) - 1 - longint'($urandom_range(255))
             : longint'(lookup_board.knot_x[n-1]) + 1 + longint'($urandom_range(255));
      else
         q = longint'(int'($urandom));
      if (q < Q_MIN || q > Q_MAX) q = longint'(int'($urandom));
      return q[31:0];
   endfunction

   // Reload the first n breakpoints: sorted noise, a tight ascending walk,
   // sorted with repeated x, or now and then an unsorted table.
   task automatic load_random_table(input int unsigned n);
      int          xs[$];
      int unsigned shape;
      longint      walk, yv;
      shape = $urandom_range(9);
      if (shape >= 5 && shape <= 7) begin
         walk = longint'(int'($urandom)) >>> 1;
         for (int k = 0; k < n; k++) begin
            xs.push_back(int'((walk > Q_MAX) ? Q_MAX : walk));
            walk += $urandom_range(1 << $urandom_range(24, 0), 1);
         end
      end else begin
         for (int k = 0; k < n; k++) xs.push_back(int'($urandom));
         if (shape != 8) xs.sort();
         if (shape == 9)
            for (int k = 1; k < n; k++)
               if ($urandom_range(2) == 0) xs[k] = xs[k-1];
      end
      yv = longint'(int'($urandom));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(2) == 0)
            yv = longint'(int'($urandom));
         else
            yv += longint'(int'($urandom)) >>> $urandom_range(30, 8);
         if (yv > Q_MAX) yv = Q_MAX;
         if (yv < Q_MIN) yv = Q_MIN;
         load_point(k, xs[k], lil_pkg::data_type'(yv));
      end
   endtask

   initial begin
      int unsigned batch, drain_at, n;
      longint      span;

      req_chan.valid       <= 1'b0;
      req_chan.mode        <= lil_pkg::MODE_LOAD;
      req_chan.point_index <= '0;
      req_chan.point_x     <= '0;
      req_chan.point_y     <= '0;
      req_chan.query_x     <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.points_used <= lil_pkg::POINTS_USED_RESET;
      reset                <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole table before any lookup: x spread evenly from the most
      // negative to the most positive Q16.16 value, y swinging between extremes.
      span = 64'sd4294967295;
      for (int i = 0; i < TABLE_DEPTH; i++)
         load_point(i, lil_pkg::data_type'(Q_MIN + (longint'(i) * span) / 63),
                    (i % 2 == 0) ? lil_pkg::data_type'(Q_MIN) : lil_pkg::data_type'(Q_MAX));

      // Reset count of two: first x, last x, interior, just past the end.
      query_at(knot(0));
      query_at(knot(1));
      query_at(knot(0) + 1);
      query_at(lil_pkg::data_type'((longint'(knot(0)) + longint'(knot(1))) / 2));
      query_at(knot(1) + 1);

      // Full table: both ends of the number range, exact breakpoints,
      // rising and falling segments.
      write_points_used(lil_pkg::cfg_type'(TABLE_DEPTH));
      query_at(lil_pkg::data_type'(Q_MIN));
      query_at(lil_pkg::data_type'(Q_MAX));
      query_at('0);
      query_at(knot(10));
      query_at(knot(10) + 1);
      query_at(knot(11) - 1);

      // Counts outside the legal range clamp to two or to the table size.
      write_points_used(lil_pkg::cfg_type'(0));
      query_at(knot(1));
      query_at(knot(1) + 1);
      write_points_used(lil_pkg::cfg_type'(1));
      query_at(knot(0) + 5);
      write_points_used(lil_pkg::cfg_type'(127));
      query_at(lil_pkg::data_type'(Q_MAX));
      write_points_used(lil_pkg::cfg_type'(65));
      query_at(knot(63) - 1);

      // Pull the first x up to -1.0 (table no longer ascending) and the last
      // x below the top: extremes now fall outside the table.
      load_point(0, 32'shFFFF_0000, 32'sh0001_8000);
      load_point(TABLE_DEPTH - 1, 32'sh7FFF_0000, 32'sh8000_0000);
      query_at(lil_pkg::data_type'(Q_MIN));
      query_at(knot(0));
      query_at('0);
      query_at(lil_pkg::data_type'(Q_MAX));
      // Flat segment: dy of zero, though the query lands below the raised first x.
      load_point(20, knot(20), lookup_board.knot_y[19]);
      query_at(knot(19) + 12345);

      // Random phases: new count, usually a fresh table, then a batch of
      // mostly queries with some stray loads; drain once in every batch.
      while (item_count < ITEM_GOAL) begin
         write_points_used(pick_points_used());
         n = lookup_board.active_points();
         steady_feed = ($urandom_range(3) == 0);
         if ($urandom_range(9) < 7) load_random_table(n);
         batch = $urandom_range(40, 10);
         drain_at = $urandom_range(batch - 1);
         for (int j = 0; j < batch && item_count < ITEM_GOAL; j++) begin
            if (j == drain_at) wait_drained();
            if ($urandom_range(4) == 0)
               load_point($urandom_range(TABLE_DEPTH - 1), $urandom, $urandom);
            else
               query_at(pick_query());
         end
      end
      steady_feed = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lookup_board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
